// ----- sv/modexp_pkg.sv -----
`timescale 1ns / 1ps

package modexp_pkg;

    localparam int FIELD_BITS       = 62;
    localparam int OPERAND_BITS_DEF = 62;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_DECIDE,
        ST_MUL,
        ST_SQR,
        ST_FINISH
    } modexp_state_t;

    typedef struct packed {
        logic start;
    } mm_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

// ----- sv/modexp_mulmod.sv -----
`timescale 1ns / 1ps

module modexp_mulmod #(
    parameter int OPERAND_BITS = modexp_pkg::OPERAND_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  modexp_pkg::mm_req_t       req,
    input  logic [OPERAND_BITS-1:0]   x,
    input  logic [OPERAND_BITS-1:0]   y,
    input  logic [OPERAND_BITS-1:0]   m,
    output modexp_pkg::mm_stat_t      stat,
    output logic [OPERAND_BITS-1:0]   product
);
    import modexp_pkg::*;

    localparam int CW = (OPERAND_BITS > 1) ? $clog2(OPERAND_BITS) : 1;
    localparam int TW = OPERAND_BITS + 2;

    logic [OPERAND_BITS-1:0] acc_reg, acc_next;
    logic [OPERAND_BITS-1:0] x_reg;
    logic [OPERAND_BITS-1:0] y_reg;
    logic [OPERAND_BITS-1:0] m_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic [TW-1:0] t_sum;
    logic [TW-1:0] m_one;
    logic [TW-1:0] m_two;
    logic [TW-1:0] t_sel;

    // one left-to-right step: acc = (2*acc + bit*x) mod m
    always_comb
    begin
        m_one = TW'(m_reg);
        m_two = TW'(m_reg) << 1;
        t_sum = (TW'(acc_reg) << 1) + (y_reg[OPERAND_BITS-1] ? TW'(x_reg) : '0);
        priority if (t_sum >= m_two)
        begin
            t_sel = t_sum - m_two;
        end
        else if (t_sum >= m_one)
        begin
            t_sel = t_sum - m_one;
        end
        else
        begin
            t_sel = t_sum;
        end
        acc_next = t_sel[OPERAND_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
            m_reg   <= m;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            y_reg   <= y_reg << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(OPERAND_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (!busy_reg && !done_reg))
        else $error("multiply started while unit occupied");

    a_acc_below_m: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> (acc_reg < m_reg))
        else $error("accumulator not reduced");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("done without a running product");
`endif

endmodule

// ----- sv/modular_exponentiation.sv -----
`timescale 1ns / 1ps

// modular exponentiation, base^exponent mod modulus, one word in, one word out
// input channel: in_valid / in_ready with base_value, exponent, modulus
// output channel: out_valid / out_ready with power_result
// fields are taken at their low OPERAND_BITS bits; exponent zero gives 1
// every modular product runs on one shift-add unit, one multiplier bit a cycle
// one product reduces the base, then one squaring per exponent bit below the
// top set bit and one multiply per set bit follow
// exponent or modulus zero skips the products and goes straight to finish
// one word is in work at a time; in_ready is high while the sequencer is idle
// a finished word waits in the output register while out_ready is low, and the
// next word may already be taken in and worked on meanwhile
// reset clears the sequencer and the output valid; no word survives it

module modular_exponentiation #(
    parameter int OPERAND_BITS = modexp_pkg::OPERAND_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [modexp_pkg::FIELD_BITS-1:0] base_value,
    input  logic [modexp_pkg::FIELD_BITS-1:0] exponent,
    input  logic [modexp_pkg::FIELD_BITS-1:0] modulus,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [modexp_pkg::FIELD_BITS-1:0] power_result
);
    import modexp_pkg::*;

    localparam int N = OPERAND_BITS;

    modexp_state_t state_reg, state_next;

    logic [N-1:0] e_reg, e_next;
    logic [N-1:0] m_reg;
    logic [N-1:0] res_reg, res_next;
    logic [N-1:0] sq_reg, sq_next;
    logic [N-1:0] one_reg;
    logic [N-1:0] power_reg;
    logic         out_valid_reg;

    logic [N-1:0] in_base;
    logic [N-1:0] in_exp;
    logic [N-1:0] in_mod;
    logic [N-1:0] in_one;
    logic         accept;
    logic         out_free;
    logic [N-1:0] e_cleared;

    mm_req_t      mm_req;
    mm_stat_t     mm_stat;
    logic [N-1:0] mm_x;
    logic [N-1:0] mm_y;
    logic [N-1:0] mm_m;
    logic [N-1:0] mm_product;

    assign in_base   = base_value[N-1:0];
    assign in_exp    = exponent[N-1:0];
    assign in_mod    = modulus[N-1:0];
    assign in_one    = (in_mod == N'(1)) ? '0 : N'(1);
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign e_cleared = e_reg & ~N'(1);

    modexp_mulmod #(
        .OPERAND_BITS (N)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mm_req),
        .x       (mm_x),
        .y       (mm_y),
        .m       (mm_m),
        .stat    (mm_stat),
        .product (mm_product)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_exp == '0 || in_mod == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mm_stat.done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = e_reg[0] ? ST_MUL : ST_SQR;
            end
            ST_MUL:
            begin
                if (mm_stat.done)
                begin
                    state_next = (e_cleared == '0) ? ST_FINISH : ST_DECIDE;
                end
            end
            ST_SQR:
            begin
                if (mm_stat.done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // unit dispatch and datapath updates
    always_comb
    begin
        mm_req.start = 1'b0;
        mm_x         = sq_reg;
        mm_y         = sq_reg;
        mm_m         = m_reg;
        e_next       = e_reg;
        res_next     = res_reg;
        sq_next      = sq_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                mm_x = in_one;
                mm_y = in_base;
                mm_m = in_mod;
                if (accept)
                begin
                    e_next = in_exp;
                    if (in_exp == '0)
                    begin
                        res_next = N'(1);
                    end
                    else if (in_mod == '0)
                    begin
                        res_next = '0;
                    end
                    else
                    begin
                        mm_req.start = 1'b1;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mm_stat.done)
                begin
                    sq_next  = mm_product;
                    res_next = one_reg;
                end
            end
            ST_DECIDE:
            begin
                mm_req.start = 1'b1;
                if (e_reg[0])
                begin
                    mm_x = res_reg;
                end
            end
            ST_MUL:
            begin
                if (mm_stat.done)
                begin
                    res_next = mm_product;
                    e_next   = e_cleared;
                end
            end
            ST_SQR:
            begin
                if (mm_stat.done)
                begin
                    sq_next = mm_product;
                    e_next  = e_reg >> 1;
                end
            end
            ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        e_reg   <= e_next;
        res_reg <= res_next;
        sq_reg  <= sq_next;
        if (accept)
        begin
            m_reg    <= in_mod;
            one_reg  <= in_one;
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            power_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign power_result = FIELD_BITS'(power_reg);

`ifndef ASSERT_OFF
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mm_stat.done |-> (state_reg == ST_REDUCE || state_reg == ST_MUL
                          || state_reg == ST_SQR))
        else $error("product finished outside a waiting state");

    a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> (res_reg < m_reg && sq_reg < m_reg
                                      && e_reg != '0))
        else $error("operands not reduced at dispatch");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_REDUCE || state_reg == ST_FINISH))
        else $error("accepted word not started");
`endif

endmodule
